FILE: rtl/core/wpm_pkg.sv
// shared types, constants and codes for the wildcard priority match block
// no dependencies; imported by wpm_cell, wpm_tracker and wildcard_priority_match
package wpm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int CELL_COUNT  = MAX_PATTERN - 1;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int WORD_W      = 64;
   localparam int WORD_COUNT  = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int PRIO_W      = 3;
   localparam int SEEN_W      = $clog2(MAX_PATTERN + 2);
   localparam int PAT_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CELL_IDX_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   localparam logic [BYTE_W-1:0] STAR = 8'h2A;

   localparam logic [CSR_IDX_W-1:0] CSR_LEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT3 = 3'd4;

   typedef enum logic [PRIO_W-1:0] {
      PRIO_NONE  = 3'd0,
      PRIO_EXACT = 3'd1,
      PRIO_TRAIL = 3'd2,
      PRIO_LEAD  = 3'd3,
      PRIO_BOTH  = 3'd4,
      PRIO_STAR  = 3'd5
   } prio_type;

   typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes_type;

   // per-word step control shared by the cells and the tracker
   typedef struct packed {
      logic take;
      logic clear;
   } step_ctrl_type;

endpackage

FILE: rtl/core/wpm_cell.sv
// one cell of the match chain: holds one suffix bit and one inner bit
// depends on wpm_pkg
module wpm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  wpm_pkg::step_ctrl_type     ctrl,
   input  logic [wpm_pkg::BYTE_W-1:0] subject_byte,
   input  logic [wpm_pkg::BYTE_W-1:0] pat_byte,
   input  logic                       en_suf,
   input  logic                       en_inr,
   input  logic                       prev_suf,
   input  logic                       prev_inr,
   output logic                       suf_ff,
   output logic                       inr_ff,
   output logic                       suf_in,
   output logic                       inr_in
);
   import wpm_pkg::*;

   logic hit;

   assign hit = (subject_byte == pat_byte);

   always_comb begin
      suf_in = suf_ff;
      inr_in = inr_ff;
      if (ctrl.take) begin
         suf_in = prev_suf & hit & en_suf;
         inr_in = prev_inr & hit & en_inr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         suf_ff <= 1'b0;
         inr_ff <= 1'b0;
      end else begin
         suf_ff <= suf_in;
         inr_ff <= inr_in;
      end
   end

endmodule

FILE: rtl/core/wpm_tracker.sv
// prefix/exact tracking, length count, inner-found flag and the priority decision
// depends on wpm_pkg; takes the updated chain bits from the wpm_cell row
module wpm_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  wpm_pkg::step_ctrl_type         ctrl,
   input  logic [wpm_pkg::BYTE_W-1:0]     subject_byte,
   input  logic [wpm_pkg::LEN_W-1:0]      len,
   input  wpm_pkg::pat_bytes_type         pat,
   input  logic [wpm_pkg::CELL_COUNT-1:0] suf_next,
   input  logic [wpm_pkg::CELL_COUNT-1:0] inr_next,
   output wpm_pkg::prio_type              prio
);
   import wpm_pkg::*;

   logic              prefix_ff, prefix_in, prefix_upd;
   logic              whole_ff, whole_in, whole_upd;
   logic              found_ff, found_in, found_upd;
   logic [SEEN_W-1:0] seen_ff, seen_in, seen_upd;

   logic [LEN_W:0]         p_ext, len_ext;
   logic [BYTE_W-1:0]      pat_at_p, first_byte, last_byte;
   logic [LEN_W-1:0]       ms, mi, len_m1;
   logic [CELL_IDX_W-1:0]  suf_sel, inr_sel;
   logic                   mismatch;

   assign p_ext    = (LEN_W+1)'(seen_ff);
   assign len_ext  = {1'b0, len};
   assign pat_at_p = pat[seen_ff[PAT_IDX_W-1:0]];
   assign mismatch = (subject_byte != pat_at_p);

   assign len_m1     = len - LEN_W'(1);
   assign ms         = (len >= LEN_W'(1)) ? len - LEN_W'(1) : '0;
   assign mi         = (len >= LEN_W'(2)) ? len - LEN_W'(2) : '0;
   assign first_byte = pat[0];
   assign last_byte  = pat[len_m1[PAT_IDX_W-1:0]];
   assign suf_sel    = CELL_IDX_W'(len - LEN_W'(2));
   assign inr_sel    = CELL_IDX_W'(mi - LEN_W'(1));

   // values after this word, before any end-of-string clear
   always_comb begin
      prefix_upd = prefix_ff;
      whole_upd  = whole_ff;
      found_upd  = found_ff;
      seen_upd   = seen_ff;
      if (ctrl.take) begin
         if ((p_ext + (LEN_W+1)'(1) < len_ext) && mismatch) begin
            prefix_upd = 1'b0;
         end
         if ((p_ext < len_ext) && mismatch) begin
            whole_upd = 1'b0;
         end
         if ((mi >= LEN_W'(1)) && inr_next[inr_sel]) begin
            found_upd = 1'b1;
         end
         if (seen_ff < SEEN_W'(MAX_PATTERN + 1)) begin
            seen_upd = seen_ff + SEEN_W'(1);
         end
      end
   end

   always_comb begin
      if (len == '0) begin
         prio = PRIO_EXACT;
      end else if ((len == LEN_W'(1)) && (first_byte == STAR)) begin
         prio = PRIO_STAR;
      end else if ((LEN_W'(seen_upd) == len) && (seen_upd <= SEEN_W'(MAX_PATTERN))
                   && whole_upd) begin
         prio = PRIO_EXACT;
      end else if ((last_byte == STAR) && ((LEN_W+1)'(seen_upd) >= {1'b0, ms})
                   && prefix_upd) begin
         prio = PRIO_TRAIL;
      end else if (first_byte != STAR) begin
         prio = PRIO_NONE;
      end else if ((LEN_W+1)'(seen_upd) < {1'b0, ms}) begin
         prio = PRIO_NONE;
      end else if (suf_next[suf_sel]) begin
         prio = PRIO_LEAD;
      end else if ((last_byte == STAR) && ((mi == '0) || found_upd)) begin
         prio = PRIO_BOTH;
      end else begin
         prio = PRIO_NONE;
      end
   end

   always_comb begin
      if (ctrl.clear) begin
         prefix_in = 1'b1;
         whole_in  = 1'b1;
         found_in  = 1'b0;
         seen_in   = '0;
      end else begin
         prefix_in = prefix_upd;
         whole_in  = whole_upd;
         found_in  = found_upd;
         seen_in   = seen_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b1;
         whole_ff  <= 1'b1;
         found_ff  <= 1'b0;
         seen_ff   <= '0;
      end else begin
         prefix_ff <= prefix_in;
         whole_ff  <= whole_in;
         found_ff  <= found_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

FILE: rtl/core/wildcard_priority_match.sv
// top level of the wildcard priority matcher: pattern registers, cell row, output register
// depends on wpm_pkg, wpm_cell and wpm_tracker
//
// channel  dir  handshake          payload
// req      in   req_valid/stall    subject_byte, is_last, empty_subject
// rsp      out  rsp_valid/stall    priority_res, matched
// csr      in   csr_write          csr_index, csr_wdata
//
// one subject byte per cycle while no word marked last is held off; the cell row
// updates all chain bits in the cycle the byte is taken, and the priority lands in
// the output register in the cycle after the word marked last. reset clears pattern
// registers and match state. a word marked last is held off only while a result
// waits under rsp_stall; other words keep flowing.
module wildcard_priority_match (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wpm_pkg::BYTE_W-1:0]    req_subject_byte,
   input  logic                          req_is_last,
   input  logic                          req_empty_subject,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wpm_pkg::PRIO_W-1:0]    rsp_priority_res,
   output logic                          rsp_matched,
   input  logic                          csr_write,
   input  logic [wpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wpm_pkg::WORD_W-1:0]    csr_wdata
);
   import wpm_pkg::*;

   logic [LEN_W-1:0]  len_ff;
   logic [WORD_W-1:0] word_ff [WORD_COUNT];

   logic [LEN_W-1:0]  len, ms, mi;
   pat_bytes_type     pat;
   logic [WORD_COUNT*WORD_W-1:0] pat_flat;

   step_ctrl_type           ctrl;
   logic                    accept;
   logic [CELL_COUNT-1:0]   suf_ff, inr_ff, suf_in, inr_in;
   prio_type                prio;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PRIO_W-1:0] rsp_priority_ff, rsp_priority_in;
   logic              rsp_matched_ff, rsp_matched_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int w = 0; w < WORD_COUNT; w++) begin
            word_ff[w] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            CSR_LEN:  len_ff     <= csr_wdata[LEN_W-1:0];
            CSR_PAT0: word_ff[0] <= csr_wdata;
            CSR_PAT1: word_ff[1] <= csr_wdata;
            CSR_PAT2: word_ff[2] <= csr_wdata;
            CSR_PAT3: word_ff[3] <= csr_wdata;
            default:  ;
         endcase
      end
   end

   assign pat_flat = {word_ff[3], word_ff[2], word_ff[1], word_ff[0]};
   assign pat      = pat_flat[MAX_PATTERN*BYTE_W-1:0];
   assign len      = (len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_ff;
   assign ms       = (len >= LEN_W'(1)) ? len - LEN_W'(1) : '0;
   assign mi       = (len >= LEN_W'(2)) ? len - LEN_W'(2) : '0;

   assign req_stall  = rsp_valid_ff & rsp_stall & req_is_last;
   assign accept     = req_valid & ~req_stall;
   assign ctrl.take  = accept & ~req_empty_subject;
   assign ctrl.clear = accept & req_is_last;

   // cell j compares against pattern byte j+1 and chains from cell j-1
   for (genvar j = 0; j < CELL_COUNT; j++) begin : g_cell
      logic prev_suf, prev_inr;
      if (j == 0) begin : g_head
         assign prev_suf = 1'b1;
         assign prev_inr = 1'b1;
      end else begin : g_body
         assign prev_suf = suf_ff[j-1];
         assign prev_inr = inr_ff[j-1];
      end
      wpm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .subject_byte (req_subject_byte),
         .pat_byte     (pat[j+1]),
         .en_suf       (LEN_W'(j) < ms),
         .en_inr       (LEN_W'(j) < mi),
         .prev_suf     (prev_suf),
         .prev_inr     (prev_inr),
         .suf_ff       (suf_ff[j]),
         .inr_ff       (inr_ff[j]),
         .suf_in       (suf_in[j]),
         .inr_in       (inr_in[j])
      );
   end

   wpm_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .subject_byte (req_subject_byte),
      .len          (len),
      .pat          (pat),
      .suf_next     (suf_in),
      .inr_next     (inr_in),
      .prio         (prio)
   );

   // output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_priority_in = rsp_priority_ff;
      rsp_matched_in  = rsp_matched_ff;
      if (ctrl.clear) begin
         rsp_valid_in    = 1'b1;
         rsp_priority_in = prio;
         rsp_matched_in  = (prio != PRIO_NONE);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_priority_ff <= rsp_priority_in;
      rsp_matched_ff  <= rsp_matched_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_priority_res = rsp_priority_ff;
   assign rsp_matched      = rsp_matched_ff;

`ifndef NO_ASSERTIONS
   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_is_last) |=> rsp_valid)
      else $error("last word accepted without a result");

   a_matched_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_matched == (rsp_priority_res != PRIO_NONE)))
      else $error("matched flag disagrees with priority");

   a_priority_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_priority_res <= PRIO_STAR))
      else $error("priority code out of range");
`endif

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for wildcard_priority_match: streams subject strings against
// changing patterns and checks every priority word against a built-in match tracker
// depends on wpm_pkg and the wildcard_priority_match rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wpm_pkg::*;

   localparam int RANDOM_WORDS = 1250;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_PAT3 + 3'd1;
   localparam logic [CSR_IDX_W-1:0] PAT_INDEX [WORD_COUNT] =
      '{CSR_PAT0, CSR_PAT1, CSR_PAT2, CSR_PAT3};

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              empty;
   } subject_word_type;

   typedef struct {
      prio_type prio;
      logic     matched;
   } verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_subject_byte = '0;
   logic                 req_is_last = 1'b0;
   logic                 req_empty_subject = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PRIO_W-1:0]    rsp_priority_res;
   logic                 rsp_matched;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   wildcard_priority_match u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_subject_byte  (req_subject_byte),
      .req_is_last       (req_is_last),
      .req_empty_subject (req_empty_subject),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_priority_res  (rsp_priority_res),
      .rsp_matched       (rsp_matched),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pattern registers as the tracker sees them
   logic [LEN_W-1:0]  pat_len_reg = '0;
   logic [WORD_W-1:0] pat_word_reg [WORD_COUNT] = '{default: '0};

   // per-string match state
   logic        prefix_ok = 1'b1;
   logic        whole_ok = 1'b1;
   int unsigned bytes_in = 0;
   logic [31:0] suffix_bits = '0;
   logic [31:0] inner_bits = '0;
   logic        inner_hit = 1'b0;

   subject_word_type pending_words [$];
   verdict_type      expected_prio [$];
   subject_word_type on_bus;
   logic [BYTE_W-1:0] stage [MAX_PATTERN];

   bit presenting = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_span = 0;
   int words_queued = 0;
   int words_taken = 0;
   int settings_used = 0;
   int results_seen = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int prio_tally [6] = '{default: 0};

   function automatic int unsigned active_len();
      int unsigned n;
      n = pat_len_reg;
      return (n > MAX_PATTERN) ? MAX_PATTERN : n;
   endfunction

   function automatic logic [BYTE_W-1:0] pat_at(int unsigned i);
      if (i >= MAX_PATTERN) return '0;
      return pat_word_reg[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic logic [31:0] ones_below(int unsigned m);
      if (m >= 32) return '1;
      return (32'd1 << m) - 32'd1;
   endfunction

   function automatic void clear_match();
      prefix_ok = 1'b1;
      whole_ok = 1'b1;
      bytes_in = 0;
      suffix_bits = '0;
      inner_bits = '0;
      inner_hit = 1'b0;
   endfunction

   function automatic void absorb_byte(logic [BYTE_W-1:0] c, int unsigned len);
      int unsigned ms;
      int unsigned mi;
      logic [31:0] sm;
      logic [31:0] im;
      ms = (len >= 1) ? len - 1 : 0;
      mi = (len >= 2) ? len - 2 : 0;
      sm = '0;
      im = '0;
      if (bytes_in + 1 < len && c != pat_at(bytes_in)) prefix_ok = 1'b0;
      if (bytes_in < len && c != pat_at(bytes_in)) whole_ok = 1'b0;
      for (int j = 0; j < 31; j++) begin
         if (c == pat_at(j + 1)) begin
            if (j < ms) sm[j] = 1'b1;
            if (j < mi) im[j] = 1'b1;
         end
      end
      suffix_bits = ((suffix_bits << 1) | 32'd1) & sm & ones_below(ms);
      inner_bits = ((inner_bits << 1) | 32'd1) & im & ones_below(mi);
      if (mi >= 1 && inner_bits[mi - 1]) inner_hit = 1'b1;
      if (bytes_in < MAX_PATTERN + 1) bytes_in++;
   endfunction

   function automatic prio_type judge_priority(int unsigned len);
      logic [BYTE_W-1:0] head_b;
      logic [BYTE_W-1:0] tail_b;
      int unsigned ms;
      if (len == 0) return PRIO_EXACT;
      head_b = pat_at(0);
      tail_b = pat_at(len - 1);
      if (len == 1 && head_b == STAR) return PRIO_STAR;
      if (bytes_in == len && whole_ok) return PRIO_EXACT;
      ms = len - 1;
      if (tail_b == STAR && bytes_in >= ms && prefix_ok) return PRIO_TRAIL;
      if (head_b != STAR) return PRIO_NONE;
      // leading star with a subject too short for the pattern gives nothing
      if (bytes_in < ms) return PRIO_NONE;
      if (suffix_bits[ms - 1]) return PRIO_LEAD;
      if (tail_b == STAR && (len == 2 || inner_hit)) return PRIO_BOTH;
      return PRIO_NONE;
   endfunction

   function automatic void take_word(subject_word_type w);
      int unsigned len;
      verdict_type v;
      len = active_len();
      if (!w.empty) absorb_byte(w.data, len);
      if (!w.empty || w.last) words_taken++;
      if (w.last) begin
         v.prio = judge_priority(len);
         v.matched = (v.prio != PRIO_NONE);
         expected_prio.insert(expected_prio.size(), v);
         clear_match();
      end
   endfunction

   // sender: bursts of words with random gaps between them
   always @(negedge clock) begin
      if (!reset && !presenting && pending_words.size() > 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            on_bus = pending_words.pop_front();
            presenting = 1'b1;
            req_subject_byte <= on_bus.data;
            req_is_last <= on_bus.last;
            req_empty_subject <= on_bus.empty;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid <= presenting;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         take_word(on_bus);
         presenting = 1'b0;
      end
   end

   // receiver stall pattern, picking a new mode whenever its span runs out
   always @(negedge clock) begin
      logic s;
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 200);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0: s = 1'b0;
         1: s = ~rsp_stall;
         2: s = 1'($urandom_range(0, 1));
         default: s = ($urandom_range(0, 9) < 8);
      endcase
      rsp_stall <= s;
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_prio.size() == 0) begin
            $error("unexpected result word: priority_res %0d matched %0d",
                   rsp_priority_res, rsp_matched);
            fail_count++;
         end else begin
            want = expected_prio.pop_front();
            results_seen++;
            prio_tally[want.prio]++;
            if (rsp_priority_res !== want.prio) begin
               $error("priority_res: expected %0d, actual %0d", want.prio, rsp_priority_res);
               fail_count++;
            end
            if (rsp_matched !== want.matched) begin
               $error("matched: expected %0d, actual %0d", want.matched, rsp_matched);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, expected_prio.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [BYTE_W-1:0] pick_symbol();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return CHAR_A + 8'($urandom_range(0, 2));
         6: return STAR;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_word(logic [BYTE_W-1:0] d, logic last, logic empty);
      subject_word_type w;
      w.data = d;
      w.last = last;
      w.empty = empty;
      pending_words.insert(pending_words.size(), w);
      if (!empty || last) words_queued++;
   endtask

   task automatic queue_text(string t, bit last);
      for (int i = 0; i < t.len(); i++) queue_word(t[i], last && (i == t.len() - 1), 1'b0);
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || presenting || expected_prio.size() != 0)
         @(negedge clock);
      // a word with no result may still be in the cell row
      repeat (3) @(negedge clock);
   endtask

   task automatic write_pattern(logic [WORD_W-1:0] len_word, bit touch_spare);
      logic [WORD_W-1:0] w;
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_LEN;
      csr_wdata <= len_word;
      pat_len_reg = len_word[LEN_W-1:0];
      for (int k = 0; k < WORD_COUNT; k++) begin
         for (int b = 0; b < 8; b++) w[b * 8 +: 8] = stage[k * 8 + b];
         @(negedge clock);
         csr_index <= PAT_INDEX[k];
         csr_wdata <= w;
         pat_word_reg[k] = w;
      end
      if (touch_spare) begin
         // indexes past the last pattern word hold nothing
         @(negedge clock);
         csr_index <= CSR_SPARE + 3'($urandom_range(0, 2));
         csr_wdata <= {$urandom, $urandom};
      end
      @(negedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic set_pattern_text(string t);
      for (int i = 0; i < MAX_PATTERN; i++) stage[i] = (i < t.len()) ? t[i] : 8'h00;
      write_pattern(WORD_W'(t.len()), 1'b0);
   endtask

   task automatic random_pattern();
      int n;
      logic [WORD_W-1:0] len_word;
      case ($urandom_range(0, 19))
         0: n = 0;
         1: n = 1;
         2: n = 2;
         3: n = MAX_PATTERN;
         4: n = $urandom_range(MAX_PATTERN + 1, 63);
         5, 6: n = $urandom_range(11, MAX_PATTERN - 1);
         default: n = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 11))
         0: for (int i = 0; i < MAX_PATTERN; i++) stage[i] = 8'hFF;
         1: for (int i = 0; i < MAX_PATTERN; i++) stage[i] = 8'h00;
         2, 3: for (int i = 0; i < MAX_PATTERN; i++) stage[i] = 8'($urandom);
         default: for (int i = 0; i < MAX_PATTERN; i++) stage[i] = pick_symbol();
      endcase
      if (n >= 1) begin
         if ($urandom_range(0, 1)) stage[0] = STAR;
         if ($urandom_range(0, 1)) stage[((n > MAX_PATTERN) ? MAX_PATTERN : n) - 1] = STAR;
      end
      len_word = WORD_W'(n);
      if ($urandom_range(0, 3) == 0) len_word = {$urandom, $urandom} & ~64'h3F | len_word;
      write_pattern(len_word, $urandom_range(0, 5) == 0);
   endtask

   task automatic random_subject(bit terminate);
      int len;
      int cut;
      logic [BYTE_W-1:0] s [$];
      len = active_len();
      case ($urandom_range(0, 9))
         0, 1: for (int i = 0; i < len; i++) s.insert(s.size(), pat_at(i));
         2: begin
            for (int i = 0; i < len - 1; i++) s.insert(s.size(), pat_at(i));
            repeat ($urandom_range(0, 5)) s.insert(s.size(), pick_symbol());
         end
         3: begin
            repeat ($urandom_range(0, 5)) s.insert(s.size(), pick_symbol());
            for (int i = 1; i < len; i++) s.insert(s.size(), pat_at(i));
         end
         4, 5: begin
            repeat ($urandom_range(0, 5)) s.insert(s.size(), pick_symbol());
            for (int i = 1; i < len - 1; i++) s.insert(s.size(), pat_at(i));
            repeat ($urandom_range(0, 5)) s.insert(s.size(), pick_symbol());
         end
         6: begin
            for (int i = 0; i < len; i++) s.insert(s.size(), pat_at(i));
            if (s.size() > 0) s[$urandom_range(0, s.size() - 1)] = pick_symbol();
         end
         7: begin
            // short subject, with or without the leading byte
            cut = $urandom_range(0, 1);
            for (int i = cut; i < $urandom_range(0, len); i++) s.insert(s.size(), pat_at(i));
         end
         8: repeat ($urandom_range(0, 12)) s.insert(s.size(), pick_symbol());
         default: repeat ($urandom_range(30, 40)) s.insert(s.size(), pick_symbol());
      endcase
      cut = (terminate && $urandom_range(0, 7) != 0) ? 0 : 1;
      for (int i = 0; i < s.size(); i++) begin
         if ($urandom_range(0, 15) == 0) queue_word(8'($urandom), 1'b0, 1'b1);
         queue_word(s[i], terminate && cut == 0 && i == s.size() - 1, 1'b0);
      end
      if (terminate && (cut == 1 || s.size() == 0)) queue_word(8'($urandom), 1'b1, 1'b1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pattern with an empty subject and with one byte
      queue_word(8'h00, 1'b1, 1'b1);
      queue_word(8'hFF, 1'b1, 1'b0);
      wait_idle();
      set_pattern_text("*");
      queue_word(8'h00, 1'b1, 1'b0);
      wait_idle();
      // two stars: empty inner part, then an empty subject that is too short
      set_pattern_text("**");
      queue_text("q", 1'b1);
      queue_word(8'h00, 1'b1, 1'b1);
      wait_idle();
      set_pattern_text("ab*");
      queue_text("abX", 1'b1);
      queue_word("a", 1'b0, 1'b0);
      queue_word(8'h55, 1'b0, 1'b1);
      queue_word("b", 1'b1, 1'b0);
      wait_idle();
      set_pattern_text("*cd");
      queue_text("xxcd", 1'b1);
      queue_text("d", 1'b1);
      wait_idle();
      set_pattern_text("*abc*");
      queue_text("abc", 1'b1);
      queue_text("zabcz", 1'b1);
      wait_idle();
      set_pattern_text("ab");
      queue_text("ab", 1'b0);
      queue_word(8'h00, 1'b1, 1'b1);
      // new pattern arrives part way through a string
      queue_text("ab", 1'b0);
      wait_idle();
      set_pattern_text("ab*");
      queue_text("c", 1'b1);
      wait_idle();

      while (words_queued < RANDOM_WORDS + 30) begin
         random_pattern();
         repeat ($urandom_range(3, 8)) random_subject(1'b1);
         if ($urandom_range(0, 5) == 0) random_subject(1'b0);
         wait_idle();
      end
      random_pattern();
      random_subject(1'b1);
      wait_idle();
      repeat (8) @(negedge clock);

      $display("%0d subject words taken under %0d pattern settings, %0d results checked",
               words_taken, settings_used, results_seen);
      $display("results by priority: none %0d exact %0d trail %0d lead %0d both %0d star %0d",
               prio_tally[PRIO_NONE], prio_tally[PRIO_EXACT], prio_tally[PRIO_TRAIL],
               prio_tally[PRIO_LEAD], prio_tally[PRIO_BOTH], prio_tally[PRIO_STAR]);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
